// ===== design/variable_record_ring_fifo_core_defines.svh =====
// Assertion macros for the variable record ring FIFO core.
`ifndef VARIABLE_RECORD_RING_FIFO_CORE_DEFINES_SVH
`define VARIABLE_RECORD_RING_FIFO_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// plain property, sampled on the rising clock, off while reset is low
`define VRRF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same-cycle implication
`define VRRF_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define VRRF_ASSERT(lbl, clk, rst_n, prop, msg)
`define VRRF_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

// ===== design/vrrf_pkg.sv =====
// Types, constants and helpers of the variable record ring FIFO.
`timescale 1ns / 1ps
`default_nettype none

package vrrf_pkg;

  localparam int unsigned RingBytes    = 4096;
  localparam int unsigned PtrW         = $clog2(RingBytes);
  localparam int unsigned FreeW        = PtrW + 1;
  localparam int unsigned GuardBytes   = 8;
  localparam int unsigned MinRecordLen = 8;
  localparam int unsigned HdrBytes     = 4;
  localparam int unsigned RecLenW      = 13;
  localparam int unsigned MaxLenW      = 12;
  localparam logic [MaxLenW-1:0] MaxLenReset = MaxLenW'(1024);

  typedef logic [PtrW-1:0] ptr_t;

  typedef enum logic [2:0] {
    ACT_CLEAR   = 3'd0,
    ACT_RESERVE = 3'd1,
    ACT_WRITE   = 3'd2,
    ACT_READ    = 3'd3,
    ACT_DISCARD = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_BAD_LEN  = 3'd2,
    STAT_NO_SPACE = 3'd3,
    STAT_NO_RESV  = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]         action;
    logic [RecLenW-1:0] record_length;
    logic [7:0]         data_in;
    logic               consume;
  } in_word_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [7:0]       data_out;
    logic             last_byte;
    logic [FreeW-1:0] free_bytes;
    logic             is_empty;
    logic             is_full;
  } out_word_t;

  // usable free space: ring minus committed bytes minus guard gap
  function automatic logic [FreeW-1:0] free_of(ptr_t front, ptr_t back);
    logic [PtrW-1:0]  used;
    logic [FreeW-1:0] u;
    used = back - front;
    u    = {1'b0, used} + FreeW'(GuardBytes);
    return (u >= FreeW'(RingBytes)) ? '0 : FreeW'(RingBytes) - u;
  endfunction

  // a zero header length counts as one byte
  function automatic logic [MaxLenW-1:0] span_of(logic [MaxLenW-1:0] len);
    return (len == '0) ? MaxLenW'(1) : len;
  endfunction

endpackage

`default_nettype wire

// ===== design/variable_record_ring_fifo_core.sv =====
// Variable length record ring FIFO: top level with control sequencer.
// Channels: in (valid/ready, one in_word_t per word: action, length, byte,
// consume flag), out (valid/ready, one out_word_t per accepted word) and a
// cfg write channel that loads max_record_len (always ready).
// Records live in a 4096 byte RAM, each framed by a 4-byte little-endian
// length header; reserve writes the header, write-byte words fill the body,
// read-byte words stream the front record, discard drops it, clear empties.
// Result path (accept to result in the out register):
//   clear, write byte, failed or ignored words, discard with the front
//   header cached: result loaded when the word is accepted
//   reserve ok: result on accept, then ST_HWR writes header bytes 1 to 3
//   read byte with the front header cached: RAM data read in ST_DATA
//   read byte after the front record changed: ST_HDR0, ST_HDR1, ST_DATA;
//   discard: ST_HDR0, ST_HDR1; two RAM reads fetch the header first.
// One word is in flight at a time; a reserve holds input until ST_HWR ends.
// Reset: pointers zero, no reservation open, max_record_len 1024; RAM
// contents are not cleared and need no clearing pass.
// A stalled receiver holds the result and in_ready stays low until it is
// taken, so at most one result waits and nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none
`include "variable_record_ring_fifo_core_defines.svh"

module variable_record_ring_fifo_core
  import vrrf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire in_word_t           in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_word_t               out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [MaxLenW-1:0] cfg_data_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HWR  = 3'd1;
  localparam logic [2:0] ST_HDR0 = 3'd2;
  localparam logic [2:0] ST_HDR1 = 3'd3;
  localparam logic [2:0] ST_DATA = 3'd4;

  logic [2:0]         state_q, state_d;
  ptr_t               front_q, front_d;
  ptr_t               back_q, back_d;
  ptr_t               cursor_q, cursor_d;
  logic [RecLenW-1:0] remain_q, remain_d;
  logic [MaxLenW-1:0] roff_q, roff_d;
  logic [MaxLenW-1:0] flen_q, flen_d;
  logic               flen_vld_q, flen_vld_d;
  logic [7:0]         lo_q, lo_d;
  logic [7:0]         hbyte_q, hbyte_d;
  ptr_t               hptr_q, hptr_d;
  logic [1:0]         hcnt_q, hcnt_d;
  logic               discard_q, discard_d;
  logic               consume_q, consume_d;
  logic [MaxLenW-1:0] max_len_q;
  out_word_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic       mem_we, mem_re;
  ptr_t       mem_waddr, mem_raddr;
  logic [7:0] mem_wdata, mem_rdata;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  vrrf_ram #(
    .Depth(RingBytes),
    .Width(8)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    logic               accept;
    logic               empty;
    logic               load;
    logic [2:0]         status;
    logic [7:0]         dout;
    logic               last;
    logic [MaxLenW-1:0] span;
    logic [MaxLenW-1:0] off;
    logic [MaxLenW-1:0] hlen;
    logic [FreeW-1:0]   free_now;
    logic [RecLenW-1:0] rec_len;

    state_d     = state_q;
    front_d     = front_q;
    back_d      = back_q;
    cursor_d    = cursor_q;
    remain_d    = remain_q;
    roff_d      = roff_q;
    flen_d      = flen_q;
    flen_vld_d  = flen_vld_q;
    lo_d        = lo_q;
    hbyte_d     = hbyte_q;
    hptr_d      = hptr_q;
    hcnt_d      = hcnt_q;
    discard_d   = discard_q;
    consume_d   = consume_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    mem_we    = 1'b0;
    mem_waddr = back_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = front_q;

    accept   = in_valid_i && in_ready_o;
    empty    = (front_q == back_q);
    load     = 1'b0;
    status   = STAT_OK;
    dout     = '0;
    last     = 1'b0;
    span     = span_of(flen_q);
    off      = (roff_q >= span) ? '0 : roff_q;
    hlen     = {mem_rdata[MaxLenW-9:0], lo_q};
    free_now = free_of(front_q, back_q);
    rec_len  = in_data_i.record_length;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          load = 1'b1;
          case (in_data_i.action)
            ACT_CLEAR: begin
              front_d    = '0;
              back_d     = '0;
              cursor_d   = '0;
              remain_d   = '0;
              roff_d     = '0;
              flen_vld_d = 1'b0;
            end
            ACT_RESERVE: begin
              flen_vld_d = 1'b0;
              if (rec_len < RecLenW'(MinRecordLen) || rec_len > {1'b0, max_len_q}) begin
                status = STAT_BAD_LEN;
              end else if (free_now < rec_len) begin
                status = STAT_NO_SPACE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = back_q;
                mem_wdata = rec_len[7:0];
                hptr_d    = back_q + PtrW'(1);
                hbyte_d   = 8'(rec_len >> 8);
                hcnt_d    = '0;
                state_d   = ST_HWR;
                cursor_d  = back_q + PtrW'(HdrBytes);
                remain_d  = rec_len - RecLenW'(HdrBytes);
                if (rec_len == RecLenW'(HdrBytes)) begin
                  back_d = back_q + PtrW'(HdrBytes);
                end
              end
            end
            ACT_WRITE: begin
              if (remain_q == '0) begin
                status = STAT_NO_RESV;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cursor_q;
                mem_wdata = in_data_i.data_in;
                cursor_d  = cursor_q + PtrW'(1);
                remain_d  = remain_q - RecLenW'(1);
                if (remain_q == RecLenW'(1)) begin
                  back_d = cursor_q + PtrW'(1);
                end
              end
            end
            ACT_READ, ACT_DISCARD: begin
              discard_d = (in_data_i.action == ACT_DISCARD);
              consume_d = in_data_i.consume;
              if (empty) begin
                status = STAT_EMPTY;
              end else if (flen_vld_q && in_data_i.action == ACT_DISCARD) begin
                front_d    = front_q + PtrW'(span);
                roff_d     = '0;
                flen_vld_d = 1'b0;
              end else if (flen_vld_q) begin
                load      = 1'b0;
                roff_d    = off;
                mem_re    = 1'b1;
                mem_raddr = front_q + PtrW'(off);
                state_d   = ST_DATA;
              end else begin
                load      = 1'b0;
                mem_re    = 1'b1;
                mem_raddr = front_q;
                state_d   = ST_HDR0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_HWR: begin
        // header bytes 1..3; only byte 1 can be nonzero
        mem_we    = 1'b1;
        mem_waddr = hptr_q;
        mem_wdata = (hcnt_q == '0) ? hbyte_q : '0;
        hptr_d    = hptr_q + PtrW'(1);
        hcnt_d    = hcnt_q + 2'd1;
        if (hcnt_q == 2'(HdrBytes - 2)) begin
          state_d = ST_IDLE;
        end
      end
      ST_HDR0: begin
        lo_d      = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = front_q + PtrW'(1);
        state_d   = ST_HDR1;
      end
      ST_HDR1: begin
        flen_d     = hlen;
        flen_vld_d = 1'b1;
        span       = span_of(hlen);
        off        = (roff_q >= span) ? '0 : roff_q;
        if (discard_q) begin
          front_d    = front_q + PtrW'(span);
          roff_d     = '0;
          flen_vld_d = 1'b0;
          load       = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          roff_d    = off;
          mem_re    = 1'b1;
          mem_raddr = front_q + PtrW'(off);
          state_d   = ST_DATA;
        end
      end
      ST_DATA: begin
        dout = mem_rdata;
        load = 1'b1;
        if (roff_q == span - MaxLenW'(1)) begin
          last   = 1'b1;
          roff_d = '0;
          if (consume_q) begin
            front_d    = front_q + PtrW'(span);
            flen_vld_d = 1'b0;
          end
        end else begin
          roff_d = roff_q + MaxLenW'(1);
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (load) begin
      out_valid_d          = 1'b1;
      out_d.status         = status;
      out_d.data_out       = dout;
      out_d.last_byte      = last;
      out_d.free_bytes     = free_of(front_d, back_d);
      out_d.is_empty       = (front_d == back_d);
      out_d.is_full        = (free_of(front_d, back_d) == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      back_q      <= '0;
      cursor_q    <= '0;
      remain_q    <= '0;
      roff_q      <= '0;
      flen_vld_q  <= 1'b0;
      hcnt_q      <= '0;
      out_valid_q <= 1'b0;
      max_len_q   <= MaxLenReset;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      back_q      <= back_d;
      cursor_q    <= cursor_d;
      remain_q    <= remain_d;
      roff_q      <= roff_d;
      flen_vld_q  <= flen_vld_d;
      hcnt_q      <= hcnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_len_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    flen_q    <= flen_d;
    lo_q      <= lo_d;
    hbyte_q   <= hbyte_d;
    hptr_q    <= hptr_d;
    discard_q <= discard_d;
    consume_q <= consume_d;
    out_q     <= out_d;
  end

  // the result slot stays empty while a read or discard is in flight
  `VRRF_ASSERT_IMP(a_slot_free_in_read, clk_i, rst_ni,
    (state_q == ST_HDR0 || state_q == ST_HDR1 || state_q == ST_DATA),
    !out_valid_q, "result slot busy during read")

  // a data fetch always runs with a known front header
  `VRRF_ASSERT_IMP(a_data_has_len, clk_i, rst_ni, state_q == ST_DATA, flen_vld_q,
    "data fetch without header")

  // cached read offset stays inside the front record
  `VRRF_ASSERT_IMP(a_roff_in_record, clk_i, rst_ni, (flen_vld_q && state_q == ST_IDLE),
    roff_q < span_of(flen_q), "read offset past record end")

  // committed bytes never eat into the guard gap
  `VRRF_ASSERT(a_guard_kept, clk_i, rst_ni,
    ptr_t'(back_q - front_q) <= ptr_t'(RingBytes - GuardBytes), "guard gap violated")

endmodule

`default_nettype wire

// ===== design/vrrf_ram.sv =====
// Single-port-write, registered-read byte RAM holding the ring storage.
`timescale 1ns / 1ps
`default_nettype none

module vrrf_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== verif/tb_variable_record_ring_fifo_core.sv =====
// Self-checking testbench for the variable record ring FIFO core.
`timescale 1ns / 1ps

module tb_variable_record_ring_fifo_core;
  import vrrf_pkg::*;

  // Tracks ring contents and pointers, predicts one result word per input word.
  class ring_scoreboard;
    logic [7:0]         store [RingBytes];
    ptr_t               front;
    ptr_t               back;
    ptr_t               wr_cursor;
    logic [RecLenW-1:0] wr_left;
    logic [RecLenW-1:0] rd_off;
    logic [MaxLenW-1:0] max_len;
    out_word_t          pending[$];
    int unsigned        errors;
    int unsigned        n_checked;
    int unsigned        n_full;
    int unsigned        status_seen[5];

    function new();
      front     = '0;
      back      = '0;
      wr_cursor = '0;
      wr_left   = '0;
      rd_off    = '0;
      max_len   = MaxLenReset;
    endfunction

    function int unsigned free_now();
      ptr_t used;
      used = back - front;
      return (used + GuardBytes >= RingBytes) ? 0 : RingBytes - used - GuardBytes;
    endfunction

    // length field of the front record, zero taken as one
    function logic [31:0] front_span();
      logic [31:0] hdr;
      ptr_t        at;
      hdr = '0;
      for (int i = 0; i < HdrBytes; i++) begin
        at = front + ptr_t'(i);
        hdr[8*i +: 8] = store[at];
      end
      return (hdr == 0) ? 32'd1 : hdr;
    endfunction

    // bytes still to read up to and including the last byte of the front record
    function int unsigned front_left();
      logic [31:0] span;
      if (front == back) return 0;
      span = front_span();
      return (rd_off >= span) ? span : span - rd_off;
    endfunction

    function void note_word(in_word_t w);
      out_word_t   r;
      logic [31:0] span;
      ptr_t        at;
      logic        was_empty;
      int unsigned free;
      r = '0;
      was_empty = (front == back);
      case (w.action)
        ACT_CLEAR: begin
          front     = '0;
          back      = '0;
          wr_cursor = '0;
          wr_left   = '0;
          rd_off    = '0;
        end
        ACT_RESERVE: begin
          if (w.record_length < MinRecordLen || w.record_length > max_len) begin
            r.status = STAT_BAD_LEN;
          end else if (free_now() < w.record_length) begin
            r.status = STAT_NO_SPACE;
          end else begin
            for (int i = 0; i < HdrBytes; i++) begin
              at = back + ptr_t'(i);
              store[at] = 8'(w.record_length >> (8 * i));
            end
            wr_cursor = back + ptr_t'(HdrBytes);
            wr_left   = w.record_length - RecLenW'(HdrBytes);
            if (wr_left == 0) back = wr_cursor;
          end
        end
        ACT_WRITE: begin
          if (wr_left == 0) begin
            r.status = STAT_NO_RESV;
          end else begin
            store[wr_cursor] = w.data_in;
            wr_cursor = wr_cursor + 1'b1;
            wr_left   = wr_left - 1'b1;
            if (wr_left == 0) back = wr_cursor;
          end
        end
        ACT_READ: begin
          if (was_empty) begin
            r.status = STAT_EMPTY;
          end else begin
            span = front_span();
            if (rd_off >= span) rd_off = '0;
            at = front + ptr_t'(rd_off);
            r.data_out = store[at];
            if (rd_off == span - 1) begin
              r.last_byte = 1'b1;
              rd_off = '0;
              if (w.consume) front = front + ptr_t'(span);
            end else begin
              rd_off = rd_off + 1'b1;
            end
          end
        end
        ACT_DISCARD: begin
          if (was_empty) begin
            r.status = STAT_EMPTY;
          end else begin
            front  = front + ptr_t'(front_span());
            rd_off = '0;
          end
        end
        default: ;
      endcase
      free = free_now();
      r.free_bytes = FreeW'(free);
      r.is_empty   = (front == back);
      r.is_full    = (free == 0);
      if (r.is_full) n_full++;
      status_seen[r.status]++;
      pending.push_back(r);
    endfunction

    function void cmp(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        $error("result word with nothing pending: %p", got);
        errors++;
        return;
      end
      want = pending[0];
      pending.delete(0);
      n_checked++;
      cmp("status", want.status, got.status);
      cmp("data_out", want.data_out, got.data_out);
      cmp("last_byte", want.last_byte, got.last_byte);
      cmp("free_bytes", want.free_bytes, got.free_bytes);
      cmp("is_empty", want.is_empty, got.is_empty);
      cmp("is_full", want.is_full, got.is_full);
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_word_t           in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_word_t          out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [MaxLenW-1:0] cfg_data_i  = '0;

  ring_scoreboard sb = new();
  int unsigned    n_items   = 0;
  int unsigned    n_ignored = 0;
  int unsigned    n_limits  = 0;
  int unsigned    tx_calm   = 0;
  int unsigned    rx_calm   = 0;
  bit             hold_out  = 1'b0;

  variable_record_ring_fifo_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #24000000;
    $display("FAIL variable_record_ring_fifo_core");
    $finish;
  end

  // mostly no gap or a short one, now and then a long one or a quiet stretch
  function automatic int unsigned idle_gap(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm = $urandom_range(20, 120);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_word(out_data_o);
  end

  initial begin : result_sink
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if (hold_out) begin
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_out = 1'b0;
      end else begin
        gap = idle_gap(rx_calm);
        if (gap != 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic send_word(logic [2:0] act, int unsigned len, int unsigned byt, bit cons);
    in_word_t    w;
    int unsigned gap;
    w.action        = act;
    w.record_length = RecLenW'(len);
    w.data_in       = 8'(byt);
    w.consume       = cons;
    gap = idle_gap(tx_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(w);
    if (act > ACT_DISCARD) n_ignored++;
    else n_items++;
  endtask

  // fields the action does not use get random values
  task automatic send_op(logic [2:0] act);
    send_word(act, $urandom_range(0, 8191), $urandom_range(0, 255), 1'($urandom_range(0, 1)));
  endtask

  // reserve, then n_body body bytes; fewer than len-4 leaves the record open
  task automatic store_record(int unsigned len, int unsigned n_body, bit noisy);
    send_word(ACT_RESERVE, len, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
    for (int unsigned k = 0; k < n_body; k++) begin
      if (noisy && $urandom_range(0, 19) == 0) send_op(ACT_READ);
      send_word(ACT_WRITE, $urandom_range(0, 8191), $urandom_range(0, 255),
                1'($urandom_range(0, 1)));
    end
  endtask

  // read the rest of the front record; only consume on its last byte counts
  task automatic fetch_front(bit take);
    int unsigned left;
    left = sb.front_left();
    if (left == 0) send_op(ACT_READ);
    while (left != 0) begin
      send_word(ACT_READ, $urandom_range(0, 8191), $urandom_range(0, 255),
                (left == 1) ? take : 1'($urandom_range(0, 1)));
      left--;
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending.size() != 0);
  endtask

  // header writes of a reserve may still be under way after its result
  task automatic settle();
    wait_drained();
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_length_limit(logic [MaxLenW-1:0] limit);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= limit;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.max_len = limit;
    n_limits++;
  endtask

  task automatic run_mix(int unsigned quota);
    int unsigned start, pick, len, cap;
    start = n_items;
    while (n_items - start < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 38 && sb.free_now() < 64) pick = pick + 40;
      if (pick < 38) begin
        pick = $urandom_range(0, 99);
        cap = (pick < 75) ? 40 : (pick < 98) ? 160 : 1024;
        if (cap > sb.max_len) cap = sb.max_len;
        len = $urandom_range(MinRecordLen, cap);
        if ($urandom_range(0, 9) != 0) store_record(len, len - HdrBytes, 1'b1);
        else store_record(len, $urandom_range(0, len - HdrBytes - 1), 1'b1);
      end else if (pick < 60) begin
        fetch_front($urandom_range(0, 3) != 0);
      end else if (pick < 66) begin
        repeat ($urandom_range(1, 6)) send_op(ACT_READ);
      end else if (pick < 72) begin
        send_op(ACT_DISCARD);
      end else if (pick < 73) begin
        send_op(ACT_CLEAR);
      end else if (pick < 76) begin
        wait_drained();
      end else begin
        send_op(3'($urandom_range(1, 7)));
      end
    end
  endtask

  initial begin : stimulus
    int k;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_op(ACT_READ);
    send_op(ACT_DISCARD);
    send_op(ACT_WRITE);
    send_word(ACT_RESERVE, 0, 0, 0);
    send_word(ACT_RESERVE, MinRecordLen - 1, 0, 0);
    send_word(ACT_RESERVE, MaxLenReset + 1, 0, 0);
    send_word(ACT_RESERVE, MaxLenReset, 0, 0);
    // abandons the open reservation
    send_word(ACT_RESERVE, MinRecordLen, 0, 0);
    send_word(ACT_WRITE, 0, 8'h00, 0);
    send_word(ACT_WRITE, 0, 8'hff, 1);
    send_word(ACT_WRITE, 0, 8'ha5, 0);
    send_word(ACT_WRITE, 0, 8'h5a, 1);
    send_op(ACT_DISCARD + 3'd1);
    send_op(ACT_DISCARD + 3'd3);
    // consume dropped on the last byte: peek, rewinds
    for (k = 0; k < MinRecordLen; k++) send_word(ACT_READ, 0, 0, k != MinRecordLen - 1);
    for (k = 0; k < 3; k++) send_word(ACT_READ, 0, 0, 1);
    send_op(ACT_DISCARD);
    send_word(ACT_RESERVE, MinRecordLen, 0, 0);
    send_op(ACT_WRITE);
    send_op(ACT_CLEAR);
    send_op(ACT_WRITE);

    set_length_limit(MaxLenW'(4088));
    send_word(ACT_RESERVE, 4088, 0, 0);
    send_word(ACT_RESERVE, 4089, 0, 0);
    store_record(200, 196, 1'b0);
    store_record(120, 116, 1'b0);
    send_word(ACT_RESERVE, 89, 0, 0);
    send_op(ACT_DISCARD);
    store_record(60, 56, 1'b0);
    fetch_front(1'b1);
    fetch_front(1'b0);
    fetch_front(1'b1);
    send_op(ACT_DISCARD);

    set_length_limit(MaxLenW'(MinRecordLen));
    run_mix(300);
    set_length_limit(MaxLenW'(4087));
    hold_out = 1'b1;
    run_mix(300);
    set_length_limit(MaxLenW'($urandom_range(8, 4088)));
    run_mix(300);
    set_length_limit(MaxLenReset);
    run_mix(300);
    settle();

    $display("Covered %0d words (+%0d unused codes), %0d results checked, %0d length limits",
             n_items, n_ignored, sb.n_checked, n_limits);
    $display("ok/empty/bad-len/no-space/no-resv = %0d/%0d/%0d/%0d/%0d, full ring seen %0d times",
             sb.status_seen[STAT_OK], sb.status_seen[STAT_EMPTY], sb.status_seen[STAT_BAD_LEN],
             sb.status_seen[STAT_NO_SPACE], sb.status_seen[STAT_NO_RESV], sb.n_full);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS variable_record_ring_fifo_core");
    end else begin
      $display("FAIL variable_record_ring_fifo_core");
    end
    $finish;
  end

endmodule
